// File: hdl/pwbf_pkg.sv
`default_nettype none
package pwbf_pkg;

	// Frame layout
	localparam int FRAME_LEN = 11;
	localparam int STEP_W    = 4;
	localparam logic [7:0] HDR0 = 8'hC8;
	localparam logic [7:0] HDR1 = 8'h8B;

	// Register map: one register, word index in paddr[2]
	localparam int APB_ADDR_W = 3;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic [7:0] THRESHOLD_RESET = 8'd16;

	// Decoded symbol from the timing unit
	typedef struct packed {
		logic valid;
		logic zero;
	} sym_t;

	// Framer result toward the output register
	typedef struct packed {
		logic              valid;
		logic [7:0]        frame_byte;
		logic [STEP_W-1:0] byte_position;
		logic              frame_last;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/pwbf_if.sv
`default_nettype none
interface pwbf_edge_if;
	logic        valid;
	logic        ready;
	logic        edge_rising;
	logic [15:0] edge_time;

	modport source (output valid, output edge_rising, output edge_time, input ready);
	modport sink   (input valid, input edge_rising, input edge_time, output ready);
endinterface

interface pwbf_byte_if;
	logic                       valid;
	logic                       ready;
	logic [7:0]                 frame_byte;
	logic [pwbf_pkg::STEP_W-1:0] byte_position;
	logic                       frame_last;

	modport source (output valid, output frame_byte, output byte_position,
		output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input byte_position,
		input frame_last, output ready);
endinterface
`default_nettype wire

// File: hdl/pwbf_symbol.sv
`default_nettype none
module pwbf_symbol (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          edge_rising,
	input  wire logic [15:0]   edge_time,
	input  wire logic [7:0]    bit_threshold,
	output pwbf_pkg::sym_t     sym
);

	logic [15:0] fall_stamp_q;
	logic [15:0] rise_stamp_q;
	logic [7:0]  low_scaled_q;
	logic        rise_pending_q;

	logic [15:0] low_width;
	logic [15:0] high_width;
	logic [7:0]  high_scaled;
	logic [7:0]  diff;

	// Measure widths modulo 2^16, scale by 8 and compare
	always_comb begin
		low_width   = edge_time - fall_stamp_q;
		high_width  = edge_time - rise_stamp_q;
		high_scaled = high_width[10:3];
		diff        = (high_scaled > low_scaled_q) ? (high_scaled - low_scaled_q)
			: (low_scaled_q - high_scaled);
		sym.valid   = advance && !edge_rising && rise_pending_q;
		sym.zero    = diff < bit_threshold;
	end

	// Hold edge stamps and the pending low width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_stamp_q   <= '0;
			rise_stamp_q   <= '0;
			low_scaled_q   <= '0;
			rise_pending_q <= 1'b0;
		end else if (advance) begin
			if (edge_rising) begin
				rise_stamp_q   <= edge_time;
				low_scaled_q   <= low_width[10:3];
				rise_pending_q <= 1'b1;
			end else begin
				fall_stamp_q   <= edge_time;
				rise_pending_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/pwbf_framer.sv
`default_nettype none
module pwbf_framer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pwbf_pkg::sym_t sym,
	output pwbf_pkg::res_t      res
);

	localparam logic [pwbf_pkg::STEP_W:0]   LEN_EXT  = (pwbf_pkg::STEP_W+1)'(pwbf_pkg::FRAME_LEN);
	localparam logic [pwbf_pkg::STEP_W-1:0] LAST_POS =
		pwbf_pkg::STEP_W'(pwbf_pkg::FRAME_LEN - 1);

	logic                          in_byte_q;
	logic [2:0]                    bit_index_q;
	logic [7:0]                    shift_byte_q;
	logic [pwbf_pkg::STEP_W-1:0]   frame_step_q;

	logic [7:0]                    byte_next;
	logic                          byte_done;
	logic                          step_ok;
	logic                          hdr_ok;
	logic [pwbf_pkg::STEP_W-1:0]   step_next;

	// Assemble the byte and check it against the frame position
	always_comb begin
		byte_next = shift_byte_q;
		byte_next[bit_index_q] = !sym.zero;
		byte_done = sym.valid && in_byte_q && (bit_index_q == 3'd7);
		step_ok   = {1'b0, frame_step_q} < LEN_EXT;
		case (frame_step_q)
			'0:      hdr_ok = byte_next == pwbf_pkg::HDR0;
			1:       hdr_ok = byte_next == pwbf_pkg::HDR1;
			default: hdr_ok = 1'b1;
		endcase
		if (!step_ok || !hdr_ok) begin
			step_next = '0;
		end else if (frame_step_q == LAST_POS) begin
			step_next = '0;
		end else begin
			step_next = frame_step_q + 1'b1;
		end
		res.valid         = byte_done && step_ok && hdr_ok;
		res.frame_byte    = byte_next;
		res.byte_position = frame_step_q;
		res.frame_last    = frame_step_q == LAST_POS;
	end

	// Advance byte collection and framer position per symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_byte_q    <= 1'b0;
			bit_index_q  <= '0;
			shift_byte_q <= '0;
			frame_step_q <= '0;
		end else if (sym.valid) begin
			if (!in_byte_q) begin
				if (sym.zero) begin
					in_byte_q   <= 1'b1;
					bit_index_q <= '0;
				end
			end else begin
				shift_byte_q <= byte_next;
				bit_index_q  <= bit_index_q + 1'b1;
				if (byte_done) begin
					in_byte_q    <= 1'b0;
					frame_step_q <= step_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/pulse_width_bit_frame_decoder.sv
// Pulse-width bit and frame decoder.
// edge_in carries one word per pin edge: polarity and a 16-bit capture
// timestamp. Rising/falling pairs are measured, the scaled low and high
// widths' difference compared against bit_threshold, and the symbols are
// assembled LSB first into bytes after a zero start symbol. A framer
// checks the two header bytes and emits each accepted byte on byte_out
// with its position; the last byte of the frame has frame_last set.
// A word held in the input register is decoded as it moves on; its result
// (if any) goes to the output register behind byte_out. One word per cycle
// is taken in steady state; the input register and the output register
// decouple the two sides, so edge_in keeps flowing while a result waits,
// and stalls only once both registers are full and byte_out.ready is low.
// The APB port holds bit_threshold at byte address 0 (reset 16); write it
// only while the block is idle.
// Reset clears all timing, byte and framer state and empties both
// registers; no clearing pass is needed.
`default_nettype none
module pulse_width_bit_frame_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pwbf_edge_if.sink                            edge_in,
	pwbf_byte_if.source                          byte_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pwbf_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic                 valid_s1;
	logic                 rising_s1;
	logic [15:0]          time_s1;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic [pwbf_pkg::STEP_W-1:0] pos_q;
	logic                 last_q;
	logic [7:0]           threshold_q;
	logic                 advance;
	pwbf_pkg::sym_t       sym;
	pwbf_pkg::res_t       res;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pwbf_pkg::REG_THRESHOLD) ? {24'd0, threshold_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= pwbf_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == pwbf_pkg::REG_THRESHOLD) begin
			threshold_q <= pwdata[7:0];
		end
	end

	// Handshake: the input word moves on whenever the output slot frees up
	assign advance       = valid_s1 && (!out_valid_q || byte_out.ready);
	assign edge_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			valid_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.valid && edge_in.ready) begin
			rising_s1 <= edge_in.edge_rising;
			time_s1   <= edge_in.edge_time;
		end
	end

	pwbf_symbol u_symbol (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.edge_rising   (rising_s1),
		.edge_time     (time_s1),
		.bit_threshold (threshold_q),
		.sym           (sym)
	);

	pwbf_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym),
		.res    (res)
	);

	// Output register: load a result, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (byte_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			byte_q <= res.frame_byte;
			pos_q  <= res.byte_position;
			last_q <= res.frame_last;
		end
	end

	assign byte_out.valid         = out_valid_q;
	assign byte_out.frame_byte    = byte_q;
	assign byte_out.byte_position = pos_q;
	assign byte_out.frame_last    = last_q;

endmodule
`default_nettype wire

// File: hdl/pwbf_checker.sv
`default_nettype none
module pwbf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [7:0]                  frame_byte,
	input wire logic [pwbf_pkg::STEP_W-1:0] byte_position,
	input wire logic                        frame_last
);

	localparam logic [pwbf_pkg::STEP_W-1:0] LAST_POS =
		pwbf_pkg::STEP_W'(pwbf_pkg::FRAME_LEN - 1);

	// A stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// Last flag only at the final frame position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_last == (byte_position == LAST_POS)))
		else $error("frame_last does not match byte_position");

	// Header bytes at positions zero and one
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_position != 0 || frame_byte == pwbf_pkg::HDR0)
			&& (byte_position != 1 || frame_byte == pwbf_pkg::HDR1))
		else $error("header byte mismatch");

	// A fresh result follows an accepted input word
	a_fresh_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input word");

endmodule

bind pulse_width_bit_frame_decoder pwbf_checker u_pwbf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (edge_in.valid),
	.in_ready      (edge_in.ready),
	.out_valid     (byte_out.valid),
	.out_ready     (byte_out.ready),
	.frame_byte    (byte_out.frame_byte),
	.byte_position (byte_out.byte_position),
	.frame_last    (byte_out.frame_last)
);
`default_nettype wire

// File: verif/pulse_width_bit_frame_decoder_test.sv
module pulse_width_bit_frame_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 320;

	typedef struct {
		logic [7:0]                  value;
		logic [pwbf_pkg::STEP_W-1:0] pos;
		logic                        last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pwbf_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pwbf_edge_if edge_ch ();
	pwbf_byte_if byte_ch ();

	pulse_width_bit_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.edge_in  (edge_ch),
		.byte_out (byte_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Decoder state as the testbench sees it
	logic [7:0]                  threshold;
	logic [15:0]                 fall_mark;
	logic [15:0]                 rise_mark;
	logic [15:0]                 low_ticks;
	logic                        rise_seen;
	logic                        collecting;
	logic [3:0]                  bit_pos;
	logic [7:0]                  byte_acc;
	logic [pwbf_pkg::STEP_W-1:0] frame_pos;

	frame_byte_t pending_bytes[$];

	// Stimulus bookkeeping
	logic [15:0] pin_now;
	int unsigned items_sent;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned errors;
	int unsigned cycle_count;

	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver stalls
	always @(posedge clk) begin
		byte_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// Hand a completed byte to the framer model
	task automatic frame_byte_done(input logic [7:0] b);
		frame_byte_t rec;
		if (frame_pos >= pwbf_pkg::STEP_W'(pwbf_pkg::FRAME_LEN)) begin
			frame_pos = '0;
		end else if ((frame_pos == 0 && b != pwbf_pkg::HDR0)
			|| (frame_pos == 1 && b != pwbf_pkg::HDR1)) begin
			frame_pos = '0;
		end else begin
			rec.value = b;
			rec.pos = frame_pos;
			rec.last = (frame_pos == pwbf_pkg::STEP_W'(pwbf_pkg::FRAME_LEN - 1));
			pending_bytes.push_back(rec);
			frame_pos = rec.last ? '0 : frame_pos + 1'b1;
		end
	endtask

	// Advance the decoder model by one edge word
	task automatic decode_edge(input logic rising, input logic [15:0] stamp);
		logic [15:0] high_ticks;
		logic [7:0] lo8;
		logic [7:0] hi8;
		logic [7:0] delta;
		logic zero_sym;
		if (rising) begin
			rise_mark = stamp;
			low_ticks = stamp - fall_mark;
			rise_seen = 1'b1;
		end else begin
			fall_mark = stamp;
			if (rise_seen) begin
				rise_seen = 1'b0;
				high_ticks = stamp - rise_mark;
				lo8 = low_ticks[10:3];
				hi8 = high_ticks[10:3];
				delta = (hi8 > lo8) ? hi8 - lo8 : lo8 - hi8;
				zero_sym = (delta < threshold);
				if (!collecting) begin
					if (zero_sym) begin
						collecting = 1'b1;
						bit_pos = '0;
					end
				end else begin
					byte_acc[bit_pos[2:0]] = !zero_sym;
					bit_pos = bit_pos + 1'b1;
					if (bit_pos > 4'd7) begin
						collecting = 1'b0;
						frame_byte_done(byte_acc);
					end
				end
			end
		end
	endtask

	// Send one edge word, with optional idle cycles ahead of it
	task automatic send_edge(input logic rising, input logic [15:0] stamp);
		if ($urandom_range(99, 0) < gap_pct) begin
			edge_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < gap_pct);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.edge_rising <= rising;
		edge_ch.edge_time <= stamp;
		do @(posedge clk); while (!edge_ch.ready);
		decode_edge(rising, stamp);
		items_sent++;
	endtask

	// Pick a width whose scaled value is the given one
	function automatic logic [15:0] pick_width(input int unsigned scaled);
		logic [15:0] w;
		w = 16'((scaled << 3) | $urandom_range(7, 0));
		// Bits above the scaled byte are dropped by the decoder
		if ($urandom_range(3, 0) == 0)
			w[15:11] = 5'($urandom_range(31, 1));
		return w;
	endfunction

	// Send one rising/falling pair aimed at a zero or one symbol
	task automatic send_symbol(input logic one_sym);
		int unsigned spread;
		int unsigned lo;
		int unsigned hi;
		int unsigned tmp;
		logic [15:0] low_w;
		logic [15:0] high_w;
		if (one_sym)
			spread = $urandom_range(255, threshold);
		else if (threshold == 0)
			spread = 0;
		else
			spread = $urandom_range(int'(threshold) - 1, 0);
		lo = $urandom_range(255 - spread, 0);
		hi = lo + spread;
		if ($urandom_range(1, 0)) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		low_w = pick_width(lo);
		high_w = pick_width(hi);
		send_edge(1'b1, pin_now + low_w);
		send_edge(1'b0, pin_now + low_w + high_w);
		pin_now = pin_now + low_w + high_w;
	endtask

	task automatic send_bits(input logic [7:0] b);
		for (int i = 0; i < 8; i++)
			send_symbol(b[i]);
	endtask

	// Start symbol, then the byte LSB first
	task automatic send_byte(input logic [7:0] b);
		send_symbol(1'b0);
		send_bits(b);
	endtask

	task automatic send_frame(input int n_bytes);
		logic [7:0] b;
		for (int i = 0; i < n_bytes; i++) begin
			if (i == 0)
				b = pwbf_pkg::HDR0;
			else if (i == 1)
				b = pwbf_pkg::HDR1;
			else if ($urandom_range(7, 0) == 0)
				b = $urandom_range(1, 0) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom);
			send_byte(b);
		end
	endtask

	// Drop valid and wait until the block has nothing left in flight
	task automatic drain_words();
		edge_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {pwbf_pkg::REG_THRESHOLD, 2'b00};
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		threshold = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly framed traffic, with broken headers and pin noise mixed in
	task automatic run_traffic(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned pick;
		logic [7:0] b;
		logic [15:0] t;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99, 0);
			if (pick < 50) begin
				send_frame(pwbf_pkg::FRAME_LEN);
			end else if (pick < 62) begin
				case ($urandom_range(2, 0))
					0: begin
						b = 8'($urandom);
						if (b == pwbf_pkg::HDR0)
							b = ~b;
						send_byte(b);
						send_frame(pwbf_pkg::FRAME_LEN);
					end
					1: begin
						b = 8'($urandom);
						if (b == pwbf_pkg::HDR1)
							b = ~b;
						send_byte(pwbf_pkg::HDR0);
						send_byte(b);
					end
					default: begin
						// Rejected second header must not restart the frame
						send_byte(pwbf_pkg::HDR0);
						send_byte(pwbf_pkg::HDR0);
						send_byte(pwbf_pkg::HDR1);
					end
				endcase
			end else if (pick < 70) begin
				send_frame($urandom_range(pwbf_pkg::FRAME_LEN - 1, 1));
			end else if (pick < 80) begin
				repeat ($urandom_range(3, 1)) send_symbol(1'b1);
			end else if (pick < 90) begin
				repeat ($urandom_range(4, 1)) begin
					t = 16'($urandom);
					if ($urandom_range(1, 0)) begin
						send_edge(1'b1, t);
					end else begin
						send_edge(1'b0, t);
						pin_now = t;
					end
				end
			end else if ($urandom_range(1, 0)) begin
				// Falling edge with no rising edge ahead of it
				t = pin_now + 16'($urandom_range(4095, 0));
				send_edge(1'b0, t);
				pin_now = t;
			end else begin
				// Double rising edge, then a normal symbol
				send_edge(1'b1, pin_now + 16'($urandom_range(2047, 0)));
				send_symbol(1'($urandom_range(1, 0)));
			end
		end
	endtask

	task automatic test_edge_cases();
		// Lone falling edge at the top of the timer
		send_edge(1'b0, 16'hFFFF);
		// Rising edge across the wrap, then the longest high width
		send_edge(1'b1, 16'h0000);
		send_edge(1'b0, 16'hFFFF);
		// Double rising edge; the second one sets the low width
		send_edge(1'b1, 16'h0077);
		send_edge(1'b1, 16'h00F7);
		send_edge(1'b0, 16'h01F7);
		pin_now = 16'h01F7;
		// Byte after that start symbol is the first header
		send_bits(pwbf_pkg::HDR0);
		drain_words();
	endtask

	task automatic test_zero_threshold();
		write_threshold(8'd0);
		send_byte(pwbf_pkg::HDR0);
		send_frame(3);
		drain_words();
	endtask

	task automatic test_frames_no_idle();
		gap_pct = 0;
		stall_pct = 0;
		write_threshold(pwbf_pkg::THRESHOLD_RESET);
		run_traffic(PHASE_ITEMS);
		drain_words();
	endtask

	task automatic test_frames_sender_gaps();
		gap_pct = 57;
		stall_pct = 0;
		write_threshold(8'd255);
		run_traffic(PHASE_ITEMS);
		drain_words();
	endtask

	task automatic test_frames_receiver_stalls();
		gap_pct = 0;
		stall_pct = 57;
		write_threshold(8'd1);
		run_traffic(PHASE_ITEMS);
		drain_words();
	endtask

	task automatic test_frames_both_idle();
		gap_pct = 18;
		stall_pct = 18;
		write_threshold(8'($urandom_range(254, 2)));
		run_traffic(PHASE_ITEMS);
		drain_words();
	endtask

	// Compare each accepted byte with the oldest prediction
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte %02h pos %0d last %0b", $time,
					byte_ch.frame_byte, byte_ch.byte_position, byte_ch.frame_last);
			end else begin
				want = pending_bytes.pop_front();
				if (byte_ch.frame_byte !== want.value) begin
					errors++;
					$display("%0t: frame_byte expected %02h actual %02h", $time,
						want.value, byte_ch.frame_byte);
				end
				if (byte_ch.byte_position !== want.pos) begin
					errors++;
					$display("%0t: byte_position expected %0d actual %0d", $time,
						want.pos, byte_ch.byte_position);
				end
				if (byte_ch.frame_last !== want.last) begin
					errors++;
					$display("%0t: frame_last expected %0b actual %0b", $time,
						want.last, byte_ch.frame_last);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		edge_ch.valid = 1'b0;
		edge_ch.edge_rising = 1'b0;
		edge_ch.edge_time = '0;
		byte_ch.ready = 1'b1;
		cycle_count = 0;
		errors = 0;
		items_sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		pin_now = '0;
		threshold = pwbf_pkg::THRESHOLD_RESET;
		fall_mark = '0;
		rise_mark = '0;
		low_ticks = '0;
		rise_seen = 1'b0;
		collecting = 1'b0;
		bit_pos = '0;
		byte_acc = '0;
		frame_pos = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_zero_threshold();
		test_frames_no_idle();
		test_frames_sender_gaps();
		test_frames_receiver_stalls();
		test_frames_both_idle();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
hdl/pwbf_pkg.sv
hdl/pwbf_if.sv
hdl/pwbf_symbol.sv
hdl/pwbf_framer.sv
hdl/pulse_width_bit_frame_decoder.sv
hdl/pwbf_checker.sv
verif/pulse_width_bit_frame_decoder_test.sv
